FILE: src/x86_64_instruction_encoder_core_assert.svh
// assertion macros for the x86-64 instruction encoder core
// uses clk and rst_n of the including module; empty bodies under SYNTHESIS
`ifndef X86_64_INSTRUCTION_ENCODER_CORE_ASSERT_SVH
`define X86_64_INSTRUCTION_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define X86E_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("x86e assertion failed");
`define X86E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("x86e assertion failed");
`else
`define X86E_ASSERT_SAME(lbl, ante, cons)
`define X86E_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/x86e_pkg.sv
// shared types, opcode constants and field helpers for the x86-64 encoder
// no dependencies
package x86e_pkg;

  localparam int MAX_LEN = 10;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IN_W    = 112;

  typedef logic [7:0]               code_byte_t;
  typedef logic [MAX_LEN-1:0][7:0]  code_buf_t;
  typedef logic [LEN_W-1:0]         code_len_t;

  typedef enum logic [3:0] {
    ACT_MOVRR      = 4'd0,
    ACT_MOVRM      = 4'd1,
    ACT_MOVIMM64   = 4'd2,
    ACT_MOVIMM_OPT = 4'd3,
    ACT_CMPIMM     = 4'd4,
    ACT_JCC        = 4'd5,
    ACT_JMP        = 4'd6,
    ACT_CALLREG    = 4'd7,
    ACT_RET        = 4'd8
  } action_t;

  typedef struct packed {
    logic [3:0]  condition;
    logic [63:0] immediate;
    logic [31:0] displacement;
    logic [3:0]  src_reg;
    logic [3:0]  dst_reg;
    logic [3:0]  action;
  } instr_t;

  typedef struct packed {
    code_buf_t bytes;
    code_len_t len;
  } enc_t;

  typedef struct packed {
    logic ready;
    logic busy;
  } emit_stat_t;

  localparam code_byte_t REX_BASE   = 8'h40;
  localparam code_byte_t REX_B      = 8'h41;
  localparam code_byte_t OP_MOV_ST  = 8'h89;
  localparam code_byte_t OP_MOV_LD  = 8'h8B;
  localparam code_byte_t OP_MOV_IMM = 8'hB8;
  localparam code_byte_t OP_XOR     = 8'h33;
  localparam code_byte_t OP_CMP8    = 8'h83;
  localparam code_byte_t OP_CMP32   = 8'h81;
  localparam code_byte_t OP_JCC8    = 8'h70;
  localparam code_byte_t OP_ESC     = 8'h0F;
  localparam code_byte_t OP_JCC32   = 8'h80;
  localparam code_byte_t OP_JMP8    = 8'hEB;
  localparam code_byte_t OP_JMP32   = 8'hE9;
  localparam code_byte_t OP_GRP5    = 8'hFF;
  localparam code_byte_t OP_RET     = 8'hC3;
  localparam code_byte_t SIB_RSP    = 8'h24;

  localparam logic [1:0] MOD_IND   = 2'd0;
  localparam logic [1:0] MOD_DISP8 = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG   = 2'd3;

  localparam logic [3:0] EXT_CMP  = 4'd7;
  localparam logic [3:0] EXT_CALL = 4'd2;

  function automatic code_byte_t rex(input logic w, input logic [3:0] r,
                                     input logic [3:0] b);
    return REX_BASE | {4'b0000, w, r[3], 1'b0, b[3]};
  endfunction

  function automatic code_byte_t modrm(input logic [1:0] md, input logic [3:0] reg_f,
                                       input logic [3:0] rm);
    return {md, reg_f[2:0], rm[2:0]};
  endfunction

  // true when the 32-bit value sign-extends from its low byte
  function automatic logic fits8(input logic [31:0] v);
    return (v[31:7] == '0) || (v[31:7] == '1);
  endfunction

endpackage

FILE: src/x86e_encode.sv
// combinational encoder: one instruction request to its byte string and length
// depends on x86e_pkg
module x86e_encode (
  input  x86e_pkg::instr_t instr,
  output x86e_pkg::enc_t   enc
);

  logic [3:0]  d;
  logic [3:0]  s;
  logic [31:0] disp;
  logic [63:0] imm;
  logic        sib;
  x86e_pkg::code_byte_t opr;

  assign d    = instr.dst_reg;
  assign s    = instr.src_reg;
  assign disp = instr.displacement;
  assign imm  = instr.immediate;
  assign sib  = (s[2:0] == 3'd4);
  assign opr  = x86e_pkg::OP_MOV_IMM | {5'b00000, d[2:0]};

  always_comb begin
    enc = '0;
    case (instr.action)
      x86e_pkg::ACT_MOVRR: begin
        enc.bytes[0] = x86e_pkg::rex(1'b1, s, d);
        enc.bytes[1] = x86e_pkg::OP_MOV_ST;
        enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_REG, s, d);
        enc.len      = x86e_pkg::code_len_t'(3);
      end
      x86e_pkg::ACT_MOVRM: begin
        enc.bytes[0] = x86e_pkg::rex(1'b1, d, s);
        enc.bytes[1] = x86e_pkg::OP_MOV_LD;
        if (disp == '0 && s[2:0] != 3'd5) begin
          enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_IND, d, s);
          if (sib) begin
            enc.bytes[3] = x86e_pkg::SIB_RSP;
            enc.len      = x86e_pkg::code_len_t'(4);
          end else begin
            enc.len = x86e_pkg::code_len_t'(3);
          end
        end else if (x86e_pkg::fits8(disp)) begin
          enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_DISP8, d, s);
          if (sib) begin
            enc.bytes[3] = x86e_pkg::SIB_RSP;
            enc.bytes[4] = disp[7:0];
            enc.len      = x86e_pkg::code_len_t'(5);
          end else begin
            enc.bytes[3] = disp[7:0];
            enc.len      = x86e_pkg::code_len_t'(4);
          end
        end else begin
          enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_DISP32, d, s);
          if (sib) begin
            enc.bytes[3] = x86e_pkg::SIB_RSP;
            for (int i = 0; i < 4; i++) enc.bytes[4+i] = disp[8*i +: 8];
            enc.len = x86e_pkg::code_len_t'(8);
          end else begin
            for (int i = 0; i < 4; i++) enc.bytes[3+i] = disp[8*i +: 8];
            enc.len = x86e_pkg::code_len_t'(7);
          end
        end
      end
      x86e_pkg::ACT_MOVIMM64: begin
        enc.bytes[0] = x86e_pkg::rex(1'b1, 4'd0, d);
        enc.bytes[1] = opr;
        for (int i = 0; i < 8; i++) enc.bytes[2+i] = imm[8*i +: 8];
        enc.len = x86e_pkg::code_len_t'(10);
      end
      x86e_pkg::ACT_MOVIMM_OPT: begin
        if (imm == '0) begin
          enc.bytes[0] = x86e_pkg::rex(1'b1, d, d);
          enc.bytes[1] = x86e_pkg::OP_XOR;
          enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_REG, d, d);
          enc.len      = x86e_pkg::code_len_t'(3);
        end else if (imm[63:32] == '0) begin
          if (d[3]) begin
            enc.bytes[0] = x86e_pkg::REX_B;
            enc.bytes[1] = opr;
            for (int i = 0; i < 4; i++) enc.bytes[2+i] = imm[8*i +: 8];
            enc.len = x86e_pkg::code_len_t'(6);
          end else begin
            enc.bytes[0] = opr;
            for (int i = 0; i < 4; i++) enc.bytes[1+i] = imm[8*i +: 8];
            enc.len = x86e_pkg::code_len_t'(5);
          end
        end else begin
          enc.bytes[0] = x86e_pkg::rex(1'b1, 4'd0, d);
          enc.bytes[1] = opr;
          for (int i = 0; i < 8; i++) enc.bytes[2+i] = imm[8*i +: 8];
          enc.len = x86e_pkg::code_len_t'(10);
        end
      end
      x86e_pkg::ACT_CMPIMM: begin
        enc.bytes[0] = x86e_pkg::rex(1'b1, 4'd0, d);
        enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_REG, x86e_pkg::EXT_CMP, d);
        if (x86e_pkg::fits8(imm[31:0])) begin
          enc.bytes[1] = x86e_pkg::OP_CMP8;
          enc.bytes[3] = imm[7:0];
          enc.len      = x86e_pkg::code_len_t'(4);
        end else begin
          enc.bytes[1] = x86e_pkg::OP_CMP32;
          for (int i = 0; i < 4; i++) enc.bytes[3+i] = imm[8*i +: 8];
          enc.len = x86e_pkg::code_len_t'(7);
        end
      end
      x86e_pkg::ACT_JCC: begin
        if (x86e_pkg::fits8(disp)) begin
          enc.bytes[0] = x86e_pkg::OP_JCC8 | {4'b0000, instr.condition};
          enc.bytes[1] = disp[7:0];
          enc.len      = x86e_pkg::code_len_t'(2);
        end else begin
          enc.bytes[0] = x86e_pkg::OP_ESC;
          enc.bytes[1] = x86e_pkg::OP_JCC32 | {4'b0000, instr.condition};
          for (int i = 0; i < 4; i++) enc.bytes[2+i] = disp[8*i +: 8];
          enc.len = x86e_pkg::code_len_t'(6);
        end
      end
      x86e_pkg::ACT_JMP: begin
        if (x86e_pkg::fits8(disp)) begin
          enc.bytes[0] = x86e_pkg::OP_JMP8;
          enc.bytes[1] = disp[7:0];
          enc.len      = x86e_pkg::code_len_t'(2);
        end else begin
          enc.bytes[0] = x86e_pkg::OP_JMP32;
          for (int i = 0; i < 4; i++) enc.bytes[1+i] = disp[8*i +: 8];
          enc.len = x86e_pkg::code_len_t'(5);
        end
      end
      x86e_pkg::ACT_CALLREG: begin
        if (d[3]) begin
          enc.bytes[0] = x86e_pkg::REX_B;
          enc.bytes[1] = x86e_pkg::OP_GRP5;
          enc.bytes[2] = x86e_pkg::modrm(x86e_pkg::MOD_REG, x86e_pkg::EXT_CALL, d);
          enc.len      = x86e_pkg::code_len_t'(3);
        end else begin
          enc.bytes[0] = x86e_pkg::OP_GRP5;
          enc.bytes[1] = x86e_pkg::modrm(x86e_pkg::MOD_REG, x86e_pkg::EXT_CALL, d);
          enc.len      = x86e_pkg::code_len_t'(2);
        end
      end
      x86e_pkg::ACT_RET: begin
        enc.bytes[0] = x86e_pkg::OP_RET;
        enc.len      = x86e_pkg::code_len_t'(1);
      end
      default: begin
        enc = '0;
      end
    endcase
  end

endmodule

FILE: src/x86e_emit.sv
// byte emitter: holds one encoded instruction and shifts it out a byte per transfer
// depends on x86e_pkg
module x86e_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  enc_valid,
  input  x86e_pkg::enc_t        enc,
  output x86e_pkg::emit_stat_t  stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);

  x86e_pkg::code_buf_t bytes_r, bytes_nxt;
  x86e_pkg::code_len_t cnt_r, cnt_nxt;
  logic                xfer;
  logic                free;
  logic                load;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = (cnt_r == x86e_pkg::code_len_t'(1));
  assign xfer       = out_tvalid && out_tready;
  // free when empty or when the final byte leaves this cycle
  assign free       = (cnt_r == '0) || (xfer && out_tlast);
  assign load       = enc_valid && free;
  assign stat.ready = free;
  assign stat.busy  = out_tvalid;

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = enc.bytes;
      cnt_nxt   = enc.len;
    end else if (xfer) begin
      bytes_nxt = {8'h00, bytes_r[x86e_pkg::MAX_LEN-1:1]};
      cnt_nxt   = cnt_r - x86e_pkg::code_len_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/x86_64_instruction_encoder_core.sv
// top level of the x86-64 instruction encoder: input register, encoder, byte emitter
// depends on x86e_pkg, x86e_encode, x86e_emit and the assertion macro header
//
// usage
// - in_* channel: one instruction request per transfer; in_tdata carries
//   action, dst_reg, src_reg, displacement, immediate and condition
// - out_* channel: one machine code byte per transfer, out_tlast on the
//   final byte of each instruction
// - the request passes the input register, then the emitter byte register
// - throughput: one byte per cycle while out_tready is high; an instruction
//   is 1 to 10 bytes long; the emitter byte register sets this rate
// - a new request is taken while the previous one is still being emitted;
//   the emitter loads the next encoding in the cycle its final byte leaves
// - request with an undefined action code produces no bytes and only
//   passes through the input register
// - reset clears the input register valid flag and emitter valid state
// - when the receiver stalls, the current byte holds, the input register
//   fills and in_tready drops until the emitter frees up
module x86_64_instruction_encoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // action[3:0], dst_reg[7:4], src_reg[11:8], displacement[43:12],
  // immediate[107:44], condition[111:108]
  input  logic [x86e_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // code_byte[7:0]
  output logic [7:0]                  out_tdata,
  output logic                        out_tlast
);

`include "x86_64_instruction_encoder_core_assert.svh"

  logic                  stage_vld_r, stage_vld_nxt;
  x86e_pkg::instr_t      stage_r, stage_nxt;
  x86e_pkg::enc_t        enc;
  x86e_pkg::emit_stat_t  stat;
  logic                  in_xfer;

  assign in_tready = !stage_vld_r || stat.ready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    stage_nxt     = stage_r;
    if (in_xfer) begin
      stage_vld_nxt = 1'b1;
      stage_nxt     = x86e_pkg::instr_t'(in_tdata);
    end else if (stat.ready) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  x86e_encode u_encode (
    .instr (stage_r),
    .enc   (enc)
  );

  x86e_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .enc_valid  (stage_vld_r),
    .enc        (enc),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // bytes of one instruction follow without a gap
  `X86E_ASSERT_NEXT(a_no_gap, out_tvalid && out_tready && !out_tlast, out_tvalid)
  // an accepted request sits in the input register next cycle
  `X86E_ASSERT_NEXT(a_stage_fill, in_xfer, stage_vld_r)
  // nothing is emitted without a pending request
  `X86E_ASSERT_NEXT(a_no_extra, out_tvalid && out_tready && out_tlast && !stage_vld_r,
                    !out_tvalid)
  // emitter status agrees with the output channel
  `X86E_ASSERT_SAME(a_stat_busy, stat.busy != out_tvalid, 1'b0)

endmodule
